// ===== rtl/mfd_pkg.sv =====
// Package for the motor feedback decoder: sizes, codes, gear reciprocals
// and the motor table index function. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package mfd_pkg;

	localparam int ENCODER_SPAN  = 8192;
	localparam int BUS_COUNT     = 3;
	localparam int SLOTS_PER_BUS = 11;
	localparam int BASE_ID       = 513;
	localparam int GEAR_A        = 19;
	localparam int GEAR_B        = 36;

	localparam int WRAP_HIGH = 7000;
	localparam int WRAP_LOW  = 1000;

	localparam int HALF_SPAN  = ENCODER_SPAN / 2;
	localparam int HALF_SHIFT = $clog2(HALF_SPAN);

	localparam int ENTRY_COUNT = BUS_COUNT * SLOTS_PER_BUS;
	localparam int ENTRY_W     = $clog2(ENTRY_COUNT);

	localparam int STEP_W  = 19;
	localparam int DIFF_W  = 33;
	localparam int REL_W   = 14;
	localparam int SHAFT_W = 24;

	localparam int RECIP_W    = 33;
	localparam int PROD_W     = 16 + RECIP_W;
	localparam int QUOT_SHIFT = 24;

	localparam longint unsigned RECIP_A_L = ((64'd1 << 32) + GEAR_A - 1) / GEAR_A;
	localparam longint unsigned RECIP_B_L = ((64'd1 << 32) + GEAR_B - 1) / GEAR_B;
	localparam logic [RECIP_W-1:0] RECIP_A = RECIP_W'(RECIP_A_L);
	localparam logic [RECIP_W-1:0] RECIP_B = RECIP_W'(RECIP_B_L);

	localparam logic OP_FEEDBACK = 1'b0;
	localparam logic OP_SETUP    = 1'b1;

	localparam logic [1:0] KIND_UNSET  = 2'd0;
	localparam logic [1:0] KIND_GIMBAL = 2'd1;
	localparam logic [1:0] KIND_GEAR_A = 2'd2;
	localparam logic [1:0] KIND_GEAR_B = 2'd3;

	localparam logic [1:0] STATUS_DECODED = 2'd0;
	localparam logic [1:0] STATUS_STORED  = 2'd1;
	localparam logic [1:0] STATUS_DROPPED = 2'd2;

	function automatic logic [ENTRY_W-1:0] entry_index(input logic [1:0] bus,
			input logic [3:0] slot);
		return ENTRY_W'(int'(bus) * SLOTS_PER_BUS + int'(slot));
	endfunction

	function automatic logic [RECIP_W-1:0] gear_recip(input logic [1:0] kind);
		logic [RECIP_W-1:0] r;
		unique case (kind) inside
			KIND_GEAR_A: r = RECIP_A;
			KIND_GEAR_B: r = RECIP_B;
			KIND_UNSET, KIND_GIMBAL: r = '0;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/mfd_if.sv =====
// Valid/ready channel interfaces for the motor feedback decoder: the
// input item channel and the result channel. Depends on mfd_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface mfd_in_if import mfd_pkg::*; ();
	logic        valid;
	logic        ready;
	logic        opcode;
	logic [1:0]  bus_index;
	logic [10:0] frame_id;
	logic [55:0] payload;
	logic [3:0]  motor_slot;
	logic [1:0]  motor_kind;
	logic signed [31:0] zero_ticks;

	modport source (output valid, opcode, bus_index, frame_id, payload, motor_slot,
		motor_kind, zero_ticks, input ready);
	modport sink (input valid, opcode, bus_index, frame_id, payload, motor_slot,
		motor_kind, zero_ticks, output ready);
endinterface

interface mfd_out_if import mfd_pkg::*; ();
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [1:0]  out_bus;
	logic [3:0]  out_slot;
	logic [15:0] encoder;
	logic signed [15:0] rotor_speed;
	logic signed [15:0] current;
	logic [7:0]  temperature;
	logic signed [31:0] turn_ticks;
	logic signed [REL_W-1:0] rel_angle;
	logic        angle_valid;
	logic signed [SHAFT_W-1:0] shaft_speed;

	modport source (output valid, status, out_bus, out_slot, encoder, rotor_speed,
		current, temperature, turn_ticks, rel_angle, angle_valid, shaft_speed,
		input ready);
	modport sink (input valid, status, out_bus, out_slot, encoder, rotor_speed,
		current, temperature, turn_ticks, rel_angle, angle_valid, shaft_speed,
		output ready);
endinterface

`default_nettype wire

// ===== rtl/motor_feedback_decoder.sv =====
// Motor feedback decoder top level: motor table memories, update sequence
// and result register. Depends on mfd_pkg and the interfaces in mfd_if.
//
// Items enter on the feed channel and one result per item leaves on the
// result channel; a transfer happens when valid and ready are both high.
// Opcode 0 decodes a feedback frame into the motor table entry of its bus
// and identifier, opcode 1 stores the type and zero offset of one slot, and
// anything out of range gives a dropped status with all other fields zero.
// The table is read at the transfer edge; each item then runs through the
// count update with write back, the angle difference, and the final angle
// wrap and speed scaling. The next item is taken in the cycle after the
// result is loaded, so only one item is in flight at a time, as set by the
// single read-modify-write sequence on the motor table.
// The result register holds a finished result while the receiver stalls;
// a following item still runs, then waits in its last step until the
// register is free. Reset clears the entry valid bits at once, so every
// table entry reads as zero and unset type until written; there is no
// clearing pass and the block is ready right after reset.
`timescale 1ns / 1ps
`default_nettype none

module motor_feedback_decoder import mfd_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	mfd_in_if.sink   feed,
	mfd_out_if.source result
);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_UPDATE = 2'd1;
	localparam logic [1:0] ST_ANGLE  = 2'd2;
	localparam logic [1:0] ST_FINISH = 2'd3;

	logic [1:0] state_q;

	logic [47:0] fb_mem [ENTRY_COUNT];
	logic [33:0] cfg_mem [ENTRY_COUNT];
	logic [ENTRY_COUNT-1:0] fb_vld_q;
	logic [ENTRY_COUNT-1:0] cfg_vld_q;

	logic acc;
	logic fb_ok;
	logic set_ok;
	logic [3:0] fid_slot;
	logic [3:0] in_slot;
	logic [ENTRY_W-1:0] in_idx;
	logic [15:0] spd_in;

	logic op_s1;
	logic hit_s1;
	logic [1:0] bus_s1;
	logic [3:0] slot_s1;
	logic [ENTRY_W-1:0] idx_s1;
	logic [15:0] enc_s1;
	logic [15:0] spd_s1;
	logic [15:0] cur_s1;
	logic [7:0]  tmp_s1;
	logic [15:0] spd_abs_s1;
	logic [47:0] fb_rd_s1;
	logic [33:0] cfg_rd_s1;
	logic fb_rd_vld_s1;
	logic cfg_rd_vld_s1;

	logic [15:0] prev_enc;
	logic [31:0] cnt_old;
	logic [1:0]  kind_cur;
	logic [31:0] zero_cur;
	logic signed [STEP_W-1:0] step;
	logic [31:0] cnt_new;

	logic [31:0] cnt_s2;
	logic [31:0] zero_s2;
	logic [1:0]  kind_s2;
	logic [PROD_W-1:0] prod_s2;
	logic signed [DIFF_W-1:0] diff_s3;

	logic [REL_W-1:0] rel_val;
	logic [SHAFT_W-1:0] shaft_val;
	logic [SHAFT_W-1:0] quot;
	logic out_free;
	logic decoded;

	logic out_vld_q;
	logic [1:0]  status_q;
	logic [1:0]  bus_q;
	logic [3:0]  slot_q;
	logic [15:0] enc_q;
	logic [15:0] spd_q;
	logic [15:0] cur_q;
	logic [7:0]  tmp_q;
	logic [31:0] ticks_q;
	logic [REL_W-1:0] rel_q;
	logic angle_vld_q;
	logic [SHAFT_W-1:0] shaft_q;

	assign feed.ready = (state_q == ST_IDLE);
	assign acc = feed.valid && feed.ready;

	assign fb_ok = int'(feed.bus_index) < BUS_COUNT && int'(feed.frame_id) >= BASE_ID
		&& int'(feed.frame_id) < BASE_ID + SLOTS_PER_BUS;
	assign set_ok = int'(feed.bus_index) < BUS_COUNT
		&& int'(feed.motor_slot) < SLOTS_PER_BUS;
	assign fid_slot = 4'(feed.frame_id - 11'(BASE_ID));
	assign in_slot = (feed.opcode == OP_SETUP) ? feed.motor_slot : fid_slot;
	assign in_idx = entry_index(feed.bus_index, in_slot);
	assign spd_in = feed.payload[39:24];

	assign out_free = !out_vld_q || result.ready;
	assign decoded = hit_s1 && op_s1 == OP_FEEDBACK;

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			fb_vld_q <= '0;
			cfg_vld_q <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (state_q == ST_FINISH && out_free) begin
				out_vld_q <= 1'b1;
			end else if (result.ready) begin
				out_vld_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (acc) begin
						state_q <= ST_UPDATE;
						if (feed.opcode == OP_SETUP && set_ok) begin
							cfg_vld_q[in_idx] <= 1'b1;
						end
					end
				end
				ST_UPDATE: begin
					state_q <= ST_ANGLE;
					if (op_s1 == OP_FEEDBACK && hit_s1) begin
						fb_vld_q[idx_s1] <= 1'b1;
					end
				end
				ST_ANGLE: begin
					state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Table memories: one write and one registered read per cycle each.
	always_ff @(posedge clk) begin
		if (acc) begin
			fb_rd_s1 <= fb_mem[in_idx];
			cfg_rd_s1 <= cfg_mem[in_idx];
			fb_rd_vld_s1 <= fb_vld_q[in_idx];
			cfg_rd_vld_s1 <= cfg_vld_q[in_idx];
			if (feed.opcode == OP_SETUP && set_ok) begin
				cfg_mem[in_idx] <= {feed.motor_kind, feed.zero_ticks};
			end
		end
		if (state_q == ST_UPDATE && op_s1 == OP_FEEDBACK && hit_s1) begin
			fb_mem[idx_s1] <= {enc_s1, cnt_new};
		end
	end

	always_comb begin
		prev_enc = fb_rd_vld_s1 ? fb_rd_s1[47:32] : 16'd0;
		cnt_old = fb_rd_vld_s1 ? fb_rd_s1[31:0] : 32'd0;
		kind_cur = cfg_rd_vld_s1 ? cfg_rd_s1[33:32] : KIND_UNSET;
		zero_cur = cfg_rd_vld_s1 ? cfg_rd_s1[31:0] : 32'd0;
		if (int'(prev_enc) > WRAP_HIGH && int'(enc_s1) < WRAP_LOW) begin
			step = STEP_W'(ENCODER_SPAN) - {3'd0, prev_enc} + {3'd0, enc_s1};
		end else if (int'(prev_enc) < WRAP_LOW && int'(enc_s1) > WRAP_HIGH) begin
			step = {3'd0, enc_s1} - STEP_W'(ENCODER_SPAN) - {3'd0, prev_enc};
		end else begin
			step = {3'd0, enc_s1} - {3'd0, prev_enc};
		end
		cnt_new = cnt_old + {{(32 - STEP_W){step[STEP_W-1]}}, step};
	end

	// Wrap of the angle difference to half a span, done on the low bits, and the shaft speed scaling by gear type.
	always_comb begin
		logic [REL_W-1:0] u;
		logic mbit;
		logic unz;
		u = REL_W'(diff_s3[HALF_SHIFT-1:0]);
		mbit = diff_s3[HALF_SHIFT];
		unz = (diff_s3[HALF_SHIFT-1:0] != '0);
		if (diff_s3 > DIFF_W'(HALF_SPAN)) begin
			rel_val = mbit ? u - REL_W'(HALF_SPAN) : u;
		end else if (diff_s3 < -DIFF_W'(HALF_SPAN)) begin
			if (unz) begin
				rel_val = mbit ? u - REL_W'(HALF_SPAN) : u;
			end else begin
				rel_val = mbit ? REL_W'(HALF_SPAN) : '0;
			end
		end else begin
			rel_val = REL_W'(diff_s3);
		end
		quot = prod_s2[QUOT_SHIFT+SHAFT_W-1:QUOT_SHIFT];
		unique case (kind_s2) inside
			KIND_GIMBAL: shaft_val = {spd_s1, 8'd0};
			KIND_GEAR_A, KIND_GEAR_B: shaft_val = spd_s1[15] ? (~quot + 1'b1) : quot;
			default: shaft_val = '0;
		endcase
	end

	// Item sequence registers.
	always_ff @(posedge clk) begin
		if (acc) begin
			op_s1 <= feed.opcode;
			hit_s1 <= (feed.opcode == OP_SETUP) ? set_ok : fb_ok;
			bus_s1 <= feed.bus_index;
			slot_s1 <= in_slot;
			idx_s1 <= in_idx;
			enc_s1 <= feed.payload[55:40];
			spd_s1 <= spd_in;
			cur_s1 <= feed.payload[23:8];
			tmp_s1 <= feed.payload[7:0];
			spd_abs_s1 <= spd_in[15] ? (~spd_in + 16'd1) : spd_in;
		end
		if (state_q == ST_UPDATE) begin
			cnt_s2 <= cnt_new;
			zero_s2 <= zero_cur;
			kind_s2 <= kind_cur;
			prod_s2 <= PROD_W'(spd_abs_s1) * PROD_W'(gear_recip(kind_cur));
		end
		if (state_q == ST_ANGLE) begin
			diff_s3 <= $signed({cnt_s2[31], cnt_s2}) - $signed({zero_s2[31], zero_s2});
		end
		if (state_q == ST_FINISH && out_free) begin
			if (!hit_s1) begin
				status_q <= STATUS_DROPPED;
			end else if (op_s1 == OP_SETUP) begin
				status_q <= STATUS_STORED;
			end else begin
				status_q <= STATUS_DECODED;
			end
			bus_q <= hit_s1 ? bus_s1 : '0;
			slot_q <= hit_s1 ? slot_s1 : '0;
			enc_q <= decoded ? enc_s1 : '0;
			spd_q <= decoded ? spd_s1 : '0;
			cur_q <= decoded ? cur_s1 : '0;
			tmp_q <= decoded ? tmp_s1 : '0;
			ticks_q <= decoded ? cnt_s2 : '0;
			rel_q <= (decoded && kind_s2 == KIND_GIMBAL) ? rel_val : '0;
			angle_vld_q <= decoded && kind_s2 == KIND_GIMBAL;
			shaft_q <= decoded ? shaft_val : '0;
		end
	end

	assign result.valid = out_vld_q;
	assign result.status = status_q;
	assign result.out_bus = bus_q;
	assign result.out_slot = slot_q;
	assign result.encoder = enc_q;
	assign result.rotor_speed = spd_q;
	assign result.current = cur_q;
	assign result.temperature = tmp_q;
	assign result.turn_ticks = ticks_q;
	assign result.rel_angle = rel_q;
	assign result.angle_valid = angle_vld_q;
	assign result.shaft_speed = shaft_q;

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		feed.valid && feed.ready |=> !feed.ready)
		else $error("item taken while another is in flight");

	a_setup_marks_entry: assert property (@(posedge clk) disable iff (!arst_n)
		acc && feed.opcode == OP_SETUP && set_ok |=> cfg_vld_q[$past(in_idx)])
		else $error("stored setting not marked valid");

	a_angle_only_decoded: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.angle_valid |-> result.status == STATUS_DECODED)
		else $error("angle flagged on a result that is not a decoded frame");

	a_angle_range: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.angle_valid |->
		$signed(result.rel_angle) <= $signed(REL_W'(HALF_SPAN))
		&& $signed(result.rel_angle) >= -$signed(REL_W'(HALF_SPAN)))
		else $error("relative angle outside half a span");

endmodule

`default_nettype wire
